// ===== rtl/fci_pkg.sv =====
package fci_pkg;

  localparam int SymW        = 8;
  localparam int MaxRulesDef = 16;
  localparam int FactSlotsDef = 8;
  localparam int MaxResults  = 8;
  localparam int InDataW     = 48;
  localparam int OutUserW    = 2;

  typedef enum logic [1:0] {
    OpAddRule = 2'd0,
    OpAddFact = 2'd1,
    OpRun     = 2'd2,
    OpClear   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]      premise_count;
    logic [SymW-1:0] premise_c;
    logic [SymW-1:0] premise_b;
    logic [SymW-1:0] premise_a;
    logic [SymW-1:0] conclusion;
  } rule_t;

  localparam int RuleW = $bits(rule_t);

  typedef struct packed {
    logic load_rule;
    logic load_fact;
    logic clear;
    logic run_start;
    logic eval;
    logic rd_next;
    logic restart;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic last_rule;
    logic rule_empty;
    logic pass_added;
    logic emit_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/forward_chaining_inference.sv =====
// Forward-chaining rule engine with a stream input and a stream output.
// Input word: tuser carries the operation (add rule, add fact, run, clear);
// tdata carries the rule fields and the initial fact symbol.
// Output word: tdata carries a fact added by a run, tuser its none-added and
// goal-reached flags, tlast marks the final word of the run.
// goal_symbol is written through cfg_we_i / cfg_wdata_i; the user must write it only
// while the block idles; the block itself does not enforce this.
// Add rule, add fact and clear give no output. A run passes over the rule
// table (no pass when the table is empty), one pass more than the number of
// passes that add facts, in the single evaluation stage behind the table read port;
// then it loads each output word once the output register is free, and idles.
// A run that adds nothing gives a single word with none-added set.
// At most MaxResults words are given per run.
// Reset empties the rule table and fact store and clears goal_symbol.
// A stalled receiver holds the output register; the engine waits and takes
// no new word until the run's last word is loaded into the output register,
// where it may still wait while the next input is taken.
module forward_chaining_inference #(
  parameter int MAX_RULES  = fci_pkg::MaxRulesDef,
  parameter int FACT_SLOTS = fci_pkg::FactSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fci_pkg::SymW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // conclusion, premise_a, premise_b, premise_c, premise_count, fact_symbol, zero fill
  input  logic [fci_pkg::InDataW-1:0]   s_axis_tdata,
  // op
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_fact
  output logic [fci_pkg::SymW-1:0]      m_axis_tdata,
  // none_added, goal_reached
  output logic [fci_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast
);
  import fci_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    out_none, out_goal;

  fci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (op_e'(s_axis_tuser)),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fci_dp #(
    .MAX_RULES  (MAX_RULES),
    .FACT_SLOTS (FACT_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_fact_o  (m_axis_tdata),
    .out_none_o  (out_none),
    .out_goal_o  (out_goal),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = {out_goal, out_none};

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("none result not final or carries a fact");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_load |-> status.out_free)
    else $error("output word overwritten while stalled");

  a_eval_has_rules: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |-> (!status.rule_empty && !s_axis_tready))
    else $error("rule evaluated with empty table or while taking input");

endmodule

// ===== rtl/fci_ctrl.sv =====
module fci_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fci_pkg::op_e     op_i,
  input  fci_pkg::status_t status_i,
  output fci_pkg::cmd_t    cmd_o
);
  import fci_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (op_i)
            OpAddRule: cmd_o.load_rule = 1'b1;
            OpAddFact: cmd_o.load_fact = 1'b1;
            OpClear:   cmd_o.clear     = 1'b1;
            OpRun: begin
              cmd_o.run_start = 1'b1;
              state_d = status_i.rule_empty ? StEmit : StEval;
            end
            default: ;
          endcase
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        if (status_i.last_rule) begin
          if (status_i.pass_added) begin
            cmd_o.restart = 1'b1;
          end else begin
            state_d = StEmit;
          end
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      StEmit: begin
        if (status_i.emit_done) begin
          state_d = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/fci_dp.sv =====
module fci_dp #(
  parameter int MAX_RULES  = fci_pkg::MaxRulesDef,
  parameter int FACT_SLOTS = fci_pkg::FactSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fci_pkg::SymW-1:0]     cfg_wdata_i,
  input  logic [fci_pkg::InDataW-1:0]  in_data_i,
  input  fci_pkg::cmd_t                cmd_i,
  output fci_pkg::status_t             status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fci_pkg::SymW-1:0]     out_fact_o,
  output logic                         out_none_o,
  output logic                         out_goal_o,
  output logic                         out_last_o
);
  import fci_pkg::*;

  localparam int RuleIdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RuleCntW = $clog2(MAX_RULES + 1);
  localparam int SlotW    = (FACT_SLOTS > 1) ? $clog2(FACT_SLOTS) : 1;
  localparam int FillW    = $clog2(FACT_SLOTS + 1);
  localparam int OutW     = $clog2(MaxResults + 1);
  localparam int CmpW     = (FillW > OutW) ? FillW : OutW;

  rule_t                in_rule;
  logic [SymW-1:0]      in_fact;

  rule_t                rule_mem [MAX_RULES];
  rule_t                rdata_q;
  logic [RuleIdxW-1:0]  rule_ptr_q, rule_ptr_d;
  logic [RuleCntW-1:0]  rule_count_q;

  logic [SymW-1:0]      fact_q [FACT_SLOTS];
  logic [FillW-1:0]     fill_q, start_fill_q;
  logic                 added_q;
  logic [SymW-1:0]      goal_q;
  logic [OutW-1:0]      emit_idx_q;

  logic                 out_valid_q;
  logic [SymW-1:0]      out_fact_q;
  logic                 out_none_q, out_goal_q, out_last_q;

  logic                 hit_a, hit_b, hit_c, hit_concl, hit_goal;
  logic                 fires, store_free, ins, fact_ok;
  logic [FillW-1:0]     n_new;
  logic                 none;
  logic [CmpW-1:0]      n_out, emit_sum;
  logic [SlotW-1:0]     emit_slot;

  assign in_rule = rule_t'(in_data_i[RuleW-1:0]);
  assign in_fact = in_data_i[RuleW +: SymW];

  always_comb begin
    hit_a     = 1'b0;
    hit_b     = 1'b0;
    hit_c     = 1'b0;
    hit_concl = 1'b0;
    hit_goal  = 1'b0;
    for (int i = 0; i < FACT_SLOTS; i++) begin
      if (FillW'(i) < fill_q) begin
        hit_a     = hit_a     | (fact_q[i] == rdata_q.premise_a);
        hit_b     = hit_b     | (fact_q[i] == rdata_q.premise_b);
        hit_c     = hit_c     | (fact_q[i] == rdata_q.premise_c);
        hit_concl = hit_concl | (fact_q[i] == rdata_q.conclusion);
        hit_goal  = hit_goal  | (fact_q[i] == goal_q);
      end
    end
  end

  assign fires = (rdata_q.premise_count < 2'd1 || hit_a) &&
                 (rdata_q.premise_count < 2'd2 || hit_b) &&
                 (rdata_q.premise_count < 2'd3 || hit_c);
  assign store_free = fill_q < FillW'(FACT_SLOTS);
  assign ins = cmd_i.eval && fires && (rdata_q.conclusion != '0) && !hit_concl && store_free;
  assign fact_ok = cmd_i.load_fact && (in_fact != '0) && store_free;

  always_comb begin
    rule_ptr_d = rule_ptr_q;
    if (cmd_i.run_start || cmd_i.restart) begin
      rule_ptr_d = '0;
    end else if (cmd_i.rd_next) begin
      rule_ptr_d = rule_ptr_q + RuleIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rule && rule_count_q < RuleCntW'(MAX_RULES)) begin
      rule_mem[rule_count_q[RuleIdxW-1:0]] <= in_rule;
    end
    rdata_q <= rule_mem[rule_ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      fact_q[fill_q[SlotW-1:0]] <= rdata_q.conclusion;
    end else if (fact_ok) begin
      fact_q[fill_q[SlotW-1:0]] <= in_fact;
    end
  end

  assign n_new = fill_q - start_fill_q;
  assign none  = (n_new == '0);

  always_comb begin
    if (none) begin
      n_out = CmpW'(1);
    end else if (CmpW'(n_new) > CmpW'(MaxResults)) begin
      n_out = CmpW'(MaxResults);
    end else begin
      n_out = CmpW'(n_new);
    end
  end

  assign emit_sum  = CmpW'(start_fill_q) + CmpW'(emit_idx_q);
  assign emit_slot = emit_sum[SlotW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_ptr_q   <= '0;
      rule_count_q <= '0;
      fill_q       <= '0;
      start_fill_q <= '0;
      added_q      <= 1'b0;
      goal_q       <= '0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rule_ptr_q <= rule_ptr_d;
      if (cfg_we_i) begin
        goal_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        rule_count_q <= '0;
        fill_q       <= '0;
      end else begin
        if (cmd_i.load_rule && rule_count_q < RuleCntW'(MAX_RULES)) begin
          rule_count_q <= rule_count_q + RuleCntW'(1);
        end
        if (ins || fact_ok) begin
          fill_q <= fill_q + FillW'(1);
        end
      end
      if (cmd_i.run_start) begin
        start_fill_q <= fill_q;
        emit_idx_q   <= '0;
      end else if (cmd_i.emit_load) begin
        emit_idx_q <= emit_idx_q + OutW'(1);
      end
      if (cmd_i.run_start || cmd_i.restart || cmd_i.clear) begin
        added_q <= 1'b0;
      end else if (ins) begin
        added_q <= 1'b1;
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_fact_q <= none ? '0 : fact_q[emit_slot];
      out_none_q <= none;
      out_goal_q <= (goal_q != '0) && hit_goal;
      out_last_q <= (CmpW'(emit_idx_q) + CmpW'(1)) == n_out;
    end
  end

  assign status_o.last_rule  = (RuleCntW'(rule_ptr_q) + RuleCntW'(1)) == rule_count_q;
  assign status_o.rule_empty = (rule_count_q == '0);
  assign status_o.pass_added = added_q | ins;
  assign status_o.emit_done  = (CmpW'(emit_idx_q) == n_out);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_fact_o  = out_fact_q;
  assign out_none_o  = out_none_q;
  assign out_goal_o  = out_goal_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== tb/forward_chaining_inference_tb.sv =====
module forward_chaining_inference_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fci_pkg::*;

  localparam int NumRules     = MaxRulesDef;
  localparam int NumSlots     = FactSlotsDef;
  localparam int ItemsTarget  = 330;
  localparam int CalmItems    = 40;
  localparam int SettleCycles = 32;
  localparam int IdleLimit    = 5000;
  localparam int LongHold     = 400;
  localparam int FillW        = InDataW - RuleW - SymW;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            none_added;
    logic            goal_hit;
    logic            is_last;
  } fact_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SymW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SymW-1:0]     m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  rule_t           rule_mem [NumRules];
  int unsigned     rule_cnt;
  logic [SymW-1:0] fact_mem [NumSlots];
  logic [SymW-1:0] goal_sym;
  fact_word_t      pending_facts [$];

  int errors;
  int n_items;
  int n_runs;
  int n_checked;
  int idle_cycles;
  int sink_hold;
  bit src_gaps;
  bit sink_gaps;

  forward_chaining_inference i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit holds_symbol(logic [SymW-1:0] s);
    if (s == '0) return 1'b0;
    foreach (fact_mem[i]) begin
      if (fact_mem[i] == s) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit place_symbol(logic [SymW-1:0] s);
    foreach (fact_mem[i]) begin
      if (fact_mem[i] == '0) begin
        fact_mem[i] = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit premises_met(rule_t r);
    logic [SymW-1:0] prem [3];
    prem[0] = r.premise_a;
    prem[1] = r.premise_b;
    prem[2] = r.premise_c;
    for (int i = 0; i < int'(r.premise_count); i++) begin
      if (!holds_symbol(prem[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void step_engine(op_e op, logic [InDataW-1:0] d);
    logic [SymW-1:0] derived [$];
    logic [SymW-1:0] sym;
    bit              grew;
    bit              reached;
    rule_t           r;
    fact_word_t      w;
    case (op)
      OpAddRule: begin
        if (rule_cnt < NumRules) begin
          rule_mem[rule_cnt] = rule_t'(d[RuleW-1:0]);
          rule_cnt++;
        end
      end
      OpAddFact: begin
        sym = d[RuleW +: SymW];
        if (sym != '0) void'(place_symbol(sym));
      end
      OpClear: begin
        rule_cnt = 0;
        foreach (fact_mem[i]) fact_mem[i] = '0;
      end
      default: begin
        do begin
          grew = 1'b0;
          for (int k = 0; k < int'(rule_cnt); k++) begin
            r = rule_mem[k];
            if (premises_met(r) && r.conclusion != '0 && !holds_symbol(r.conclusion)) begin
              if (place_symbol(r.conclusion)) begin
                grew = 1'b1;
                if (derived.size() < MaxResults) derived.push_back(r.conclusion);
              end
            end
          end
        end while (grew);
        reached = (goal_sym != '0) && holds_symbol(goal_sym);
        if (derived.size() == 0) begin
          w = '{sym: '0, none_added: 1'b1, goal_hit: reached, is_last: 1'b1};
          pending_facts.push_back(w);
        end
        foreach (derived[k]) begin
          w.sym        = derived[k];
          w.none_added = 1'b0;
          w.goal_hit   = reached;
          w.is_last    = (k == derived.size() - 1);
          pending_facts.push_back(w);
        end
        n_runs++;
      end
    endcase
  endfunction

  function automatic logic [InDataW-1:0] pack_item(logic [SymW-1:0] c, logic [SymW-1:0] a,
                                                   logic [SymW-1:0] b, logic [SymW-1:0] p,
                                                   logic [1:0] cnt, logic [SymW-1:0] f);
    return {{FillW{1'b0}}, f, cnt, p, b, a, c};
  endfunction

  function automatic logic [InDataW-1:0] noise_item();
    return pack_item(SymW'($urandom_range(0, 255)), SymW'($urandom_range(0, 255)),
                     SymW'($urandom_range(0, 255)), SymW'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), SymW'($urandom_range(0, 255)));
  endfunction

  function automatic logic [SymW-1:0] pick_sym();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return SymW'($urandom_range(0, 255));
      2:       return 8'hFF;
      default: return SymW'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic send_word(op_e op, logic [InDataW-1:0] d);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    step_engine(op, d);
    n_items++;
  endtask

  task automatic add_rule(logic [SymW-1:0] c, logic [SymW-1:0] a, logic [SymW-1:0] b,
                          logic [SymW-1:0] p, logic [1:0] cnt);
    send_word(OpAddRule, pack_item(c, a, b, p, cnt, SymW'($urandom_range(0, 255))));
  endtask

  task automatic add_fact(logic [SymW-1:0] f);
    logic [InDataW-1:0] d;
    d = noise_item();
    d[RuleW +: SymW] = f;
    send_word(OpAddFact, d);
  endtask

  task automatic run_rules();
    send_word(OpRun, noise_item());
  endtask

  task automatic clear_all();
    send_word(OpClear, noise_item());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_facts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_goal(logic [SymW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    goal_sym = v;
  endtask

  task automatic report_field(string what, logic [SymW-1:0] want, logic [SymW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic check_word();
    fact_word_t want;
    if (pending_facts.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual new_fact=%0d tuser=%b tlast=%b",
               $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end else begin
      want = pending_facts.pop_front();
      report_field("new_fact", want.sym, m_axis_tdata);
      report_field("none_added", SymW'(want.none_added), SymW'(m_axis_tuser[0]));
      report_field("goal_reached", SymW'(want.goal_hit), SymW'(m_axis_tuser[1]));
      report_field("tlast", SymW'(want.is_last), SymW'(m_axis_tlast));
      n_checked++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word();
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, IdleLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic test_directed();
    set_goal(8'd6);
    run_rules();
    add_fact(8'd0);
    add_fact(8'hFF);
    add_fact(8'hFF);
    add_rule(8'd1, 8'd0, 8'd0, 8'd0, 2'd0);
    add_rule(8'd2, 8'hFF, 8'd1, 8'd0, 2'd2);
    add_rule(8'd0, 8'd2, 8'd0, 8'd0, 2'd1);
    add_rule(8'd3, 8'd0, 8'd0, 8'd0, 2'd1);
    add_rule(8'd4, 8'd2, 8'd1, 8'hFF, 2'd3);
    add_rule(8'd6, 8'd7, 8'd0, 8'd0, 2'd1);
    add_rule(8'd7, 8'd4, 8'd0, 8'd0, 2'd1);
    run_rules();
    run_rules();
    add_fact(8'd9);
    add_fact(8'd10);
    add_rule(8'd11, 8'd0, 8'd0, 8'd0, 2'd0);
    run_rules();
    clear_all();
    run_rules();
    drain();
  endtask

  task automatic test_table_full();
    set_goal(8'd200);
    clear_all();
    for (int k = 1; k <= NumRules; k++) begin
      add_rule(SymW'(k), 8'd0, SymW'($urandom_range(0, 255)), SymW'($urandom_range(0, 255)),
               2'd1);
    end
    add_rule(8'd200, 8'd0, 8'd0, 8'd0, 2'd0);
    run_rules();
    clear_all();
    add_rule(8'd200, 8'd0, 8'd0, 8'd0, 2'd0);
    run_rules();
    drain();
  endtask

  task automatic test_output_stall();
    set_goal(8'd9);
    sink_hold = LongHold;
    clear_all();
    add_fact(8'd1);
    for (int k = 8; k >= 1; k--) begin
      add_rule(SymW'(k + 1), SymW'(k), SymW'($urandom_range(0, 255)), 8'd0, 2'd1);
    end
    run_rules();
    run_rules();
    clear_all();
    add_fact(8'd1);
    add_rule(8'd2, 8'd1, 8'd1, 8'd1, 2'd3);
    run_rules();
    drain();
  endtask

  task automatic test_random_chains();
    int              phase;
    int              n_rule;
    int              n_fact;
    bit              calm;
    logic [SymW-1:0] goal;
    phase = 0;
    while (n_items < ItemsTarget) begin
      calm      = n_items >= ItemsTarget - CalmItems;
      src_gaps  = !calm && $urandom_range(0, 2) != 0;
      sink_gaps = !calm && $urandom_range(0, 2) != 0;
      if (phase % 3 == 0) begin
        drain();
        case ((phase / 3) % 4)
          0:       goal = 8'hFF;
          1:       goal = '0;
          2:       goal = 8'd1;
          default: goal = SymW'($urandom_range(1, 12));
        endcase
        set_goal(goal);
      end
      if ($urandom_range(0, 4) != 0) clear_all();
      n_fact = ($urandom_range(0, 7) == 0) ? NumSlots + 1 : $urandom_range(0, 3);
      n_rule = ($urandom_range(0, 7) == 0) ? NumRules + 2 : $urandom_range(1, 10);
      repeat (n_fact) add_fact(pick_sym());
      repeat (n_rule) begin
        if ($urandom_range(0, 7) == 0) send_word(op_e'(2'($urandom_range(0, 3))), noise_item());
        add_rule(pick_sym(), pick_sym(), pick_sym(), pick_sym(), 2'($urandom_range(0, 3)));
      end
      run_rules();
      phase++;
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpAddRule;
    rule_cnt = 0;
    goal_sym = '0;
    foreach (fact_mem[i]) fact_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    test_directed();
    test_table_full();
    test_output_stall();
    test_random_chains();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    drain();
    $display("sent %0d input words, %0d inference runs, checked %0d result words",
             n_items, n_runs, n_checked);
    $display("goal settings 0, 1, 255 and random; full tables; long output stall");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
